// ----- design/fpba_pkg.sv -----
// Package for the fit-policy block allocator.
// Holds the transaction payload structs, the code constants and the controller/datapath interface.
// No dependencies.
`timescale 1ns / 1ps

package fpba_pkg;

    // item kinds
    localparam logic KIND_LOAD    = 1'b0;
    localparam logic KIND_REQUEST = 1'b1;

    // search policies (code 3 falls back to first fit)
    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;

    // configuration register indexes
    localparam logic CFG_FIT_POLICY  = 1'b0;
    localparam logic CFG_BLOCK_COUNT = 1'b1;

    localparam int CFG_DATA_W = 5;

    typedef struct packed {
        logic        kind;
        logic [3:0]  block_index;
        logic [15:0] size;
    } in_item_t;

    typedef struct packed {
        logic       granted;
        logic [3:0] chosen_block;
        logic [7:0] request_number;
    } out_item_t;

    // controller -> datapath commands
    typedef struct packed {
        logic load;    // write an accepted load transaction into the table
        logic start;   // latch request size, clear the search
        logic scan;    // advance the search by one block
        logic commit;  // charge the chosen block, publish the result
    } dp_cmd_t;

    // datapath -> controller status
    typedef struct packed {
        logic scan_done;
        logic out_free;
    } dp_sts_t;

endpackage

// ----- design/fpba_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module fpba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    clk,
    we,
    waddr,
    wdata,
    raddr,
    rdata
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    input  logic             clk;
    input  logic             we;
    input  logic [AW-1:0]    waddr;
    input  logic [WIDTH-1:0] wdata;
    input  logic [AW-1:0]    raddr;
    output logic [WIDTH-1:0] rdata;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/fpba_dpath.sv -----
// Datapath of the fit-policy block allocator: config registers, free-size table,
// search pipeline, charge arithmetic and the output register.
// Depends on fpba_pkg and fpba_ram.
`timescale 1ns / 1ps

module fpba_dpath
    import fpba_pkg::*;
#(
    parameter int MAX_BLOCKS = 16,
    parameter int SIZE_WIDTH = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  in_item_t              in_item,
    input  dp_cmd_t               cmd,
    output dp_sts_t               sts,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_item
);
    localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam logic [CW-1:0] LIMIT_MAX = CW'(MAX_BLOCKS);

    logic [1:0]            fit_policy_reg;
    logic [CFG_DATA_W-1:0] block_count_reg;
    logic [7:0]            req_cnt_reg;

    logic [CW-1:0]         scan_idx_reg;
    logic                  rd_pend_reg;
    logic [AW-1:0]         rd_idx_reg;
    logic                  rd_vld_reg;
    logic [MAX_BLOCKS-1:0] vld_reg;

    logic                  found_reg;
    logic [AW-1:0]         best_idx_reg;
    logic [SIZE_WIDTH-1:0] best_size_reg;
    logic [SIZE_WIDTH-1:0] sz_reg;

    logic                  out_valid_reg;
    out_item_t             out_item_reg;

    logic [CW-1:0]         limit;
    logic                  issue;
    logic [AW-1:0]         scan_addr;
    logic [SIZE_WIDTH-1:0] ram_q;
    logic [SIZE_WIDTH-1:0] cand;
    logic                  fits;
    logic                  take;
    logic                  is_best;
    logic                  is_worst;
    logic [31:0]           size_ext;
    logic [31:0]           best_idx_ext;
    logic                  load_in_range;
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [SIZE_WIDTH-1:0] ram_wdata;

    // count above the table size is clipped
    always_comb
    begin
        if (32'(block_count_reg) > MAX_BLOCKS)
        begin
            limit = LIMIT_MAX;
        end
        else
        begin
            limit = CW'(block_count_reg);
        end
    end

    assign size_ext      = {16'd0, in_item.size};
    assign issue         = cmd.scan && (scan_idx_reg < limit);
    assign scan_addr     = scan_idx_reg[AW-1:0];
    assign cand          = rd_vld_reg ? ram_q : '0;
    assign fits          = sz_reg <= cand;
    assign is_best       = fit_policy_reg == POL_BEST;
    assign is_worst      = fit_policy_reg == POL_WORST;
    assign take          = cmd.scan && rd_pend_reg && fits &&
                           (!found_reg || (is_best && cand < best_size_reg) ||
                            (is_worst && cand > best_size_reg));
    assign load_in_range = 32'(in_item.block_index) < MAX_BLOCKS;

    // one write port shared by loads and the charge
    assign ram_we    = (cmd.load && load_in_range) || (cmd.commit && found_reg);
    assign ram_waddr = cmd.commit ? best_idx_reg : AW'(32'(in_item.block_index));
    assign ram_wdata = cmd.commit ? (best_size_reg - sz_reg) : size_ext[SIZE_WIDTH-1:0];

    fpba_ram #(
        .WIDTH(SIZE_WIDTH),
        .DEPTH(MAX_BLOCKS)
    ) u_free_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(scan_addr),
        .rdata(ram_q)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_policy_reg  <= POL_FIRST;
            block_count_reg <= '0;
            req_cnt_reg     <= '0;
            scan_idx_reg    <= '0;
            rd_pend_reg     <= 1'b0;
            found_reg       <= 1'b0;
            vld_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_FIT_POLICY:  fit_policy_reg  <= cfg_data[1:0];
                    CFG_BLOCK_COUNT: block_count_reg <= cfg_data;
                    default:         ;
                endcase
            end
            if (ram_we)
            begin
                vld_reg[ram_waddr] <= 1'b1;
            end
            if (cmd.start)
            begin
                scan_idx_reg <= '0;
                rd_pend_reg  <= 1'b0;
                found_reg    <= 1'b0;
            end
            else if (cmd.scan)
            begin
                rd_pend_reg <= issue;
                if (issue)
                begin
                    scan_idx_reg <= scan_idx_reg + CW'(1);
                end
                if (take)
                begin
                    found_reg <= 1'b1;
                end
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
                req_cnt_reg   <= req_cnt_reg + 8'd1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign best_idx_ext = 32'(best_idx_reg);

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            sz_reg <= size_ext[SIZE_WIDTH-1:0];
        end
        if (issue)
        begin
            rd_idx_reg <= scan_addr;
            rd_vld_reg <= vld_reg[scan_addr];
        end
        if (take)
        begin
            best_idx_reg  <= rd_idx_reg;
            best_size_reg <= cand;
        end
        if (cmd.commit)
        begin
            out_item_reg.granted        <= found_reg;
            out_item_reg.chosen_block   <= found_reg ? best_idx_ext[3:0] : 4'd0;
            out_item_reg.request_number <= req_cnt_reg;
        end
    end

    assign sts.scan_done = !rd_pend_reg && !(scan_idx_reg < limit);
    assign sts.out_free  = !out_valid_reg || !out_stall;
    assign out_valid     = out_valid_reg;
    assign out_item      = out_item_reg;

    a_charge_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && found_reg) |-> (best_size_reg >= sz_reg))
        else $error("charged block smaller than request");

    a_chosen_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && found_reg) |-> (CW'(best_idx_reg) < limit))
        else $error("chosen block outside searched range");

    a_commit_publishes: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("commit did not load the output register");

endmodule

// ----- design/fpba_ctrl.sv -----
// Controller of the fit-policy block allocator: input handshake and search sequencing.
// Depends on fpba_pkg.
`timescale 1ns / 1ps

module fpba_ctrl
    import fpba_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     in_kind,
    output logic     in_stall,
    input  dp_sts_t  sts,
    output dp_cmd_t  cmd
);
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_stall_reg;
    logic   accept;

    assign accept = in_valid && !in_stall_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_kind == KIND_REQUEST)
                    begin
                        cmd.start  = 1'b1;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        cmd.load = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            in_stall_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            in_stall_reg <= state_next != ST_IDLE;
        end
    end

    assign in_stall = in_stall_reg;

    a_stall_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall_reg == (state_reg != ST_IDLE))
        else $error("stall out of step with controller state");

    a_commit_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> (state_reg == ST_IDLE))
        else $error("controller did not return to idle after commit");

    a_scan_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan == (state_reg == ST_SCAN))
        else $error("scan command outside the scan state");

endmodule

// ----- design/fit_policy_block_allocator.sv -----
// Top level of the fit-policy block allocator.
// Depends on fpba_pkg, fpba_ctrl and fpba_dpath (which holds fpba_ram).
`timescale 1ns / 1ps

// Keeps a free-size table for up to MAX_BLOCKS memory blocks. A load transaction
// (kind 0) writes block_index's free size and gives no result; loads to a slot at or
// above MAX_BLOCKS are dropped. A request transaction (kind 1) scans blocks
// 0 .. min(block_count, MAX_BLOCKS)-1 for one whose free size covers the request:
// first fit takes the lowest index, best fit the smallest fitting block, worst fit the
// largest; ties go to the lowest index, and policy code 3 acts as first fit. The chosen
// block is charged the request size and one result goes out per request, carrying the
// grant, the block index (0 when refused) and an 8-bit wrapping request number.
// Timing: a load is taken as it arrives and the next transaction may follow at once.
// A request keeps the block busy through an accept step, a scan that reads one stored
// free size per block of N = min(block_count, MAX_BLOCKS) through the single read port
// of the free-size RAM, a step for the registered read of the last compare (when N > 0),
// a step to see the end of the scan and a charge step. The finished result sits in
// an output register, so the next transaction is taken while it waits; the charge waits
// only if that register is still full. After reset the table reads as all zero at once
// (per-entry valid bits), so there is no clearing pass. Configuration (cfg_index 0 fit_policy,
// 1 block_count) is to be written by the user only while idle; the block does not enforce it.

module fit_policy_block_allocator
    import fpba_pkg::*;
#(
    parameter int MAX_BLOCKS = 16,
    parameter int SIZE_WIDTH = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_item,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_item
);
    dp_cmd_t cmd;
    dp_sts_t sts;

    fpba_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_kind (in_item.kind),
        .in_stall(in_stall),
        .sts     (sts),
        .cmd     (cmd)
    );

    fpba_dpath #(
        .MAX_BLOCKS(MAX_BLOCKS),
        .SIZE_WIDTH(SIZE_WIDTH)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .in_item  (in_item),
        .cmd      (cmd),
        .sts      (sts),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_item (out_item)
    );

endmodule
